// ===== hw/rtl/srgr_pkg.sv =====
// Shared types and constants of the supersampled ring glyph rasterizer.
`default_nettype none

package srgr_pkg;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int IMG_W    = 9;
  localparam int GLY_W    = 9;
  localparam int RING_W   = 7;
  localparam int RAD_W    = 9;
  localparam int COLOR_W  = 24;
  localparam int CH_W     = 8;
  localparam int OFF_W    = 18;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_SIZE,
    REG_GLYPH_SIZE,
    REG_RING_WIDTH,
    REG_INNER_RADIUS,
    REG_FILL_COLOR
  } cfg_reg_e;

  // Register reset values
  localparam logic [IMG_W-1:0]   IMAGE_SIZE_RST   = 9'd16;
  localparam logic [GLY_W-1:0]   GLYPH_SIZE_RST   = 9'd14;
  localparam logic [RING_W-1:0]  RING_WIDTH_RST   = 7'd2;
  localparam logic [RAD_W-1:0]   INNER_RADIUS_RST = 9'd9;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST   = 24'hFFFFFF;

  localparam logic [CH_W-1:0] ALPHA_FULL = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [OFF_W-1:0] pixel_offset;
    logic [CH_W-1:0]  out_blue;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_alpha;
  } pix_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srgr_cfg.sv =====
// Configuration registers and the glyph geometry derived from them.
`default_nettype none

module srgr_cfg #(
  parameter int SUBSAMPLES     = 8,
  parameter int MAX_IMAGE_SIZE = 256,
  localparam int UNIT  = 2 * SUBSAMPLES,
  localparam int ISZ_W = ($clog2(MAX_IMAGE_SIZE + 1) > srgr_pkg::IMG_W) ?
                         $clog2(MAX_IMAGE_SIZE + 1) : srgr_pkg::IMG_W,
  localparam int PW    = ISZ_W + 2,
  localparam int CW    = PW + $clog2(UNIT) + 1,
  localparam int SQW   = 2 * (CW - 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [srgr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [srgr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [ISZ_W-1:0]                  isz_o,
  output logic signed [CW-1:0]              left_o,
  output logic signed [CW-1:0]              lt_o,
  output logic signed [CW-1:0]              bottom_o,
  output logic signed [CW-1:0]              bt_o,
  output logic [SQW-1:0]                    tu2_o,
  output logic [SQW-1:0]                    in_lo2_o,
  output logic [SQW-1:0]                    in_hi2_o,
  output logic [SQW-1:0]                    out_lo2_o,
  output logic [SQW-1:0]                    out_hi2_o,
  output logic [srgr_pkg::COLOR_W-1:0]      fill_color_o
);
  import srgr_pkg::*;

  logic [IMG_W-1:0]   image_size_q;
  logic [GLY_W-1:0]   glyph_size_q;
  logic [RING_W-1:0]  ring_width_q;
  logic [RAD_W-1:0]   inner_radius_q;
  logic [COLOR_W-1:0] fill_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q   <= IMAGE_SIZE_RST;
      glyph_size_q   <= GLYPH_SIZE_RST;
      ring_width_q   <= RING_WIDTH_RST;
      inner_radius_q <= INNER_RADIUS_RST;
      fill_color_q   <= FILL_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_SIZE:   image_size_q   <= cfg_data_i[IMG_W-1:0];
        REG_GLYPH_SIZE:   glyph_size_q   <= cfg_data_i[GLY_W-1:0];
        REG_RING_WIDTH:   ring_width_q   <= cfg_data_i[RING_W-1:0];
        REG_INNER_RADIUS: inner_radius_q <= cfg_data_i[RAD_W-1:0];
        REG_FILL_COLOR:   fill_color_q   <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // First level: edges and radii in units of 1/UNIT pixel
  logic [ISZ_W-1:0]     isz_d, isz_q;
  logic signed [PW-1:0] diff, margin_sum, margin, m_t, m_g, m_gt;
  logic signed [CW-1:0] left_d, lt_d, bottom_d, bt_d;
  logic signed [CW-1:0] left_q, lt_q, bottom_q, bt_q;
  logic [RAD_W-1:0]     in_lo_px, out_lo_px;
  logic [CW-2:0]        tu_d, in_lo_d, in_hi_d, out_lo_d, out_hi_d;
  logic [CW-2:0]        tu_q, in_lo_q, in_hi_q, out_lo_q, out_hi_q;

  always_comb begin
    isz_d = (ISZ_W'(image_size_q) > ISZ_W'(MAX_IMAGE_SIZE)) ?
            ISZ_W'(MAX_IMAGE_SIZE) : ISZ_W'(image_size_q);
    diff  = $signed(PW'(isz_d)) - $signed(PW'(glyph_size_q));
    // halve toward zero
    margin_sum = diff + $signed(PW'(diff[PW-1]));
    margin     = margin_sum >>> 1;
    m_t   = margin + $signed(PW'(ring_width_q));
    m_g   = margin + $signed(PW'(glyph_size_q));
    m_gt  = m_g - $signed(PW'(ring_width_q));
    left_d   = CW'(margin) * CW'(UNIT);
    lt_d     = CW'(m_t) * CW'(UNIT);
    bottom_d = CW'(m_g) * CW'(UNIT);
    bt_d     = CW'(m_gt) * CW'(UNIT);

    // clamp inner bounds at zero
    in_lo_px  = (inner_radius_q > RAD_W'(ring_width_q)) ?
                inner_radius_q - RAD_W'(ring_width_q) : '0;
    out_lo_px = (RAD_W'(glyph_size_q) > RAD_W'(ring_width_q)) ?
                RAD_W'(glyph_size_q) - RAD_W'(ring_width_q) : '0;
    tu_d     = (CW-1)'(ring_width_q) * (CW-1)'(UNIT);
    in_lo_d  = (CW-1)'(in_lo_px) * (CW-1)'(UNIT);
    in_hi_d  = (CW-1)'(inner_radius_q) * (CW-1)'(UNIT);
    out_lo_d = (CW-1)'(out_lo_px) * (CW-1)'(UNIT);
    out_hi_d = (CW-1)'(glyph_size_q) * (CW-1)'(UNIT);
  end

  always_ff @(posedge clk_i) begin
    isz_q    <= isz_d;
    left_q   <= left_d;
    lt_q     <= lt_d;
    bottom_q <= bottom_d;
    bt_q     <= bt_d;
    tu_q     <= tu_d;
    in_lo_q  <= in_lo_d;
    in_hi_q  <= in_hi_d;
    out_lo_q <= out_lo_d;
    out_hi_q <= out_hi_d;
  end

  // Second level: squared bounds
  logic [SQW-1:0] tu2_q, in_lo2_q, in_hi2_q, out_lo2_q, out_hi2_q;

  always_ff @(posedge clk_i) begin
    tu2_q     <= SQW'(tu_q) * SQW'(tu_q);
    in_lo2_q  <= SQW'(in_lo_q) * SQW'(in_lo_q);
    in_hi2_q  <= SQW'(in_hi_q) * SQW'(in_hi_q);
    out_lo2_q <= SQW'(out_lo_q) * SQW'(out_lo_q);
    out_hi2_q <= SQW'(out_hi_q) * SQW'(out_hi_q);
  end

  assign isz_o        = isz_q;
  assign left_o       = left_q;
  assign lt_o         = lt_q;
  assign bottom_o     = bottom_q;
  assign bt_o         = bt_q;
  assign tu2_o        = tu2_q;
  assign in_lo2_o     = in_lo2_q;
  assign in_hi2_o     = in_hi2_q;
  assign out_lo2_o    = out_lo2_q;
  assign out_hi2_o    = out_hi2_q;
  assign fill_color_o = fill_color_q;

endmodule

`default_nettype wire

// ===== hw/rtl/supersampled_ring_glyph_raster.sv =====
// Top level of the supersampled ring glyph rasterizer pipeline.
//
// Usage: write the five geometry and color registers on the cfg port while
// the block is idle, then stream pixel coordinates in on the in channel
// (valid/ready). Each accepted word yields exactly one out word carrying the
// byte offset and the premultiplied BGRA value of that pixel, in order.
// The datapath is an 8-register pipeline, stages 1 to 8, whose last register
// drives out_valid_o. One word is accepted per cycle in steady state while
// out_ready_i stays high. The rate is set by the per-stage lanes: all
// SUBSAMPLES x SUBSAMPLES coverage tests of a pixel are done in parallel in
// one stage, the hit count in two, the channel scaling in two.
// Reset restores the register defaults (16, 14, 2, 9, white) and empties the
// pipeline. When the receiver holds out_ready_i low, the last stage holds its
// word and earlier stages keep filling empty slots behind it; in_ready_o
// drops only once every stage is occupied. Nothing is lost or repeated.
// Derived geometry is registered in srgr_cfg after a register write.
`default_nettype none

module supersampled_ring_glyph_raster #(
  parameter int SUBSAMPLES     = 8,
  parameter int MAX_IMAGE_SIZE = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  srgr_pkg::pix_in_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output srgr_pkg::pix_out_t              out_word_o,
  input  logic                            cfg_we_i,
  input  logic [srgr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srgr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import srgr_pkg::*;

  localparam int UNIT  = 2 * SUBSAMPLES;
  localparam int NSUB  = SUBSAMPLES * SUBSAMPLES;
  localparam int ISZ_W = ($clog2(MAX_IMAGE_SIZE + 1) > IMG_W) ?
                         $clog2(MAX_IMAGE_SIZE + 1) : IMG_W;
  localparam int PW    = ISZ_W + 2;
  localparam int CW    = PW + $clog2(UNIT) + 1;
  localparam int SQW   = 2 * (CW - 1);
  localparam int DW    = SQW + 1;
  localparam int OW    = PIX_W + ISZ_W + 1;
  localparam int RCW   = $clog2(SUBSAMPLES + 1);
  localparam int HW    = $clog2(NSUB + 1);
  // exact division by NSUB through a rounded-up reciprocal
  localparam int KW    = CH_W + HW;
  localparam int LW    = $clog2(NSUB);
  localparam int MW    = KW + 2;
  localparam int Recip = ((1 << (KW + LW)) + NSUB - 1) / NSUB;
  localparam int PRW   = KW + MW;

  // Geometry
  logic [ISZ_W-1:0]     isz;
  logic signed [CW-1:0] left, lt, bottom, bt;
  logic [SQW-1:0]       tu2, in_lo2, in_hi2, out_lo2, out_hi2;
  logic [COLOR_W-1:0]   fill_color;

  srgr_cfg #(
    .SUBSAMPLES     (SUBSAMPLES),
    .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .isz_o        (isz),
    .left_o       (left),
    .lt_o         (lt),
    .bottom_o     (bottom),
    .bt_o         (bt),
    .tu2_o        (tu2),
    .in_lo2_o     (in_lo2),
    .in_hi2_o     (in_hi2),
    .out_lo2_o    (out_lo2),
    .out_hi2_o    (out_hi2),
    .fill_color_o (fill_color)
  );

  // Stage control: a stage advances when it is empty or the next one moves
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  assign en8 = !v8_q || out_ready_i;
  assign en7 = !v7_q || en8;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_ready_o  = en1;
  assign out_valid_o = v8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
      if (en8) v8_q <= v7_q;
    end
  end

  // Stage 1: input word
  logic [PIX_W-1:0] x1_q, y1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q <= in_word_i.pixel_x;
      y1_q <= in_word_i.pixel_y;
    end
  end

  // Stage 2: subsample offsets per column and per row, pixel offset
  logic signed [CW-1:0] gx_d [SUBSAMPLES];
  logic signed [CW-1:0] ex_d [SUBSAMPLES];
  logic signed [CW-1:0] gy_d [SUBSAMPLES];
  logic signed [CW-1:0] ey_d [SUBSAMPLES];
  logic signed [CW-1:0] gx2_q [SUBSAMPLES];
  logic signed [CW-1:0] ex2_q [SUBSAMPLES];
  logic signed [CW-1:0] gy2_q [SUBSAMPLES];
  logic signed [CW-1:0] ey2_q [SUBSAMPLES];
  logic signed [CW-1:0] xu, yu;
  logic [OW-1:0]        lin;
  logic [OFF_W-1:0]     off2_d, off2_q;

  always_comb begin
    xu = CW'(x1_q) * CW'(UNIT);
    yu = CW'(y1_q) * CW'(UNIT);
    for (int s = 0; s < SUBSAMPLES; s++) begin
      gx_d[s] = xu + CW'(2 * s + 1) - left;
      ex_d[s] = xu + CW'(2 * s + 1) - lt;
      gy_d[s] = bottom - yu - CW'(2 * s + 1);
      ey_d[s] = bt - yu - CW'(2 * s + 1);
    end
    lin    = OW'(y1_q) * OW'(isz) + OW'(x1_q);
    off2_d = {lin[OFF_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      gx2_q  <= gx_d;
      ex2_q  <= ex_d;
      gy2_q  <= gy_d;
      ey2_q  <= ey_d;
      off2_q <= off2_d;
    end
  end

  // Stage 3: squares; a negative gx or gy masks the subsample later
  logic [CW-2:0]    ex_mag [SUBSAMPLES];
  logic [CW-2:0]    ey_mag [SUBSAMPLES];
  logic [SQW-1:0]   gxs_q [SUBSAMPLES];
  logic [SQW-1:0]   exs_q [SUBSAMPLES];
  logic [SQW-1:0]   gys_q [SUBSAMPLES];
  logic [SQW-1:0]   eys_q [SUBSAMPLES];
  logic [SUBSAMPLES-1:0] gxn3_q, gyn3_q;
  logic [OFF_W-1:0] off3_q;

  always_comb begin
    for (int s = 0; s < SUBSAMPLES; s++) begin
      ex_mag[s] = ex2_q[s][CW-1] ? (CW-1)'(-ex2_q[s]) : ex2_q[s][CW-2:0];
      ey_mag[s] = ey2_q[s][CW-1] ? (CW-1)'(-ey2_q[s]) : ey2_q[s][CW-2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int s = 0; s < SUBSAMPLES; s++) begin
        gxs_q[s]  <= SQW'(gx2_q[s][CW-2:0]) * SQW'(gx2_q[s][CW-2:0]);
        gys_q[s]  <= SQW'(gy2_q[s][CW-2:0]) * SQW'(gy2_q[s][CW-2:0]);
        exs_q[s]  <= SQW'(ex_mag[s]) * SQW'(ex_mag[s]);
        eys_q[s]  <= SQW'(ey_mag[s]) * SQW'(ey_mag[s]);
        gxn3_q[s] <= gx2_q[s][CW-1];
        gyn3_q[s] <= gy2_q[s][CW-1];
      end
      off3_q <= off2_q;
    end
  end

  // Stage 4: one coverage test per subsample
  logic [NSUB-1:0]  hit_d, hit4_q;
  logic [DW-1:0]    d2 [NSUB];
  logic [DW-1:0]    e2 [NSUB];
  logic [OFF_W-1:0] off4_q;

  always_comb begin
    for (int sy = 0; sy < SUBSAMPLES; sy++) begin
      for (int sx = 0; sx < SUBSAMPLES; sx++) begin
        d2[sy * SUBSAMPLES + sx] = DW'(gxs_q[sx]) + DW'(gys_q[sy]);
        e2[sy * SUBSAMPLES + sx] = DW'(exs_q[sx]) + DW'(eys_q[sy]);
        hit_d[sy * SUBSAMPLES + sx] = !gxn3_q[sx] && !gyn3_q[sy] &&
          ((e2[sy * SUBSAMPLES + sx] <= DW'(tu2)) ||
           (d2[sy * SUBSAMPLES + sx] >= DW'(in_lo2) &&
            d2[sy * SUBSAMPLES + sx] <= DW'(in_hi2)) ||
           (d2[sy * SUBSAMPLES + sx] >= DW'(out_lo2) &&
            d2[sy * SUBSAMPLES + sx] <= DW'(out_hi2)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      hit4_q <= hit_d;
      off4_q <= off3_q;
    end
  end

  // Stage 5: hits per row
  logic [RCW-1:0]   rc_d [SUBSAMPLES];
  logic [RCW-1:0]   rc5_q [SUBSAMPLES];
  logic [OFF_W-1:0] off5_q;

  always_comb begin
    for (int sy = 0; sy < SUBSAMPLES; sy++) begin
      rc_d[sy] = '0;
      for (int sx = 0; sx < SUBSAMPLES; sx++) begin
        rc_d[sy] = rc_d[sy] + RCW'(hit4_q[sy * SUBSAMPLES + sx]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      rc5_q  <= rc_d;
      off5_q <= off4_q;
    end
  end

  // Stage 6: total hits
  logic [HW-1:0]    hits_d, hits6_q;
  logic [OFF_W-1:0] off6_q;

  always_comb begin
    hits_d = '0;
    for (int sy = 0; sy < SUBSAMPLES; sy++) begin
      hits_d = hits_d + HW'(rc5_q[sy]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      hits6_q <= hits_d;
      off6_q  <= off5_q;
    end
  end

  // Stage 7: channel times hits, biased for round half up
  logic [KW-1:0]    pb7_q, pg7_q, pr7_q, pa7_q;
  logic [OFF_W-1:0] off7_q;

  always_ff @(posedge clk_i) begin
    if (en7) begin
      pb7_q  <= KW'(fill_color[23:16]) * KW'(hits6_q) + KW'(NSUB / 2);
      pg7_q  <= KW'(fill_color[15:8]) * KW'(hits6_q) + KW'(NSUB / 2);
      pr7_q  <= KW'(fill_color[7:0]) * KW'(hits6_q) + KW'(NSUB / 2);
      pa7_q  <= KW'(ALPHA_FULL) * KW'(hits6_q) + KW'(NSUB / 2);
      off7_q <= off6_q;
    end
  end

  // Stage 8: divide by the subsample count, output register
  logic [PRW-1:0]   qb, qg, qr, qa;
  pix_out_t         out_d, out_q;

  always_comb begin
    qb = PRW'(pb7_q) * PRW'(Recip);
    qg = PRW'(pg7_q) * PRW'(Recip);
    qr = PRW'(pr7_q) * PRW'(Recip);
    qa = PRW'(pa7_q) * PRW'(Recip);
    out_d.pixel_offset = off7_q;
    out_d.out_blue     = qb[KW+LW+CH_W-1:KW+LW];
    out_d.out_green    = qg[KW+LW+CH_W-1:KW+LW];
    out_d.out_red      = qr[KW+LW+CH_W-1:KW+LW];
    out_d.out_alpha    = qa[KW+LW+CH_W-1:KW+LW];
  end

  always_ff @(posedge clk_i) begin
    if (en8) begin
      out_q <= out_d;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire
